>>> rtl/core/csa_pkg.sv
// Shared types and codes for the component slot allocator.
`default_nettype none
package csa_pkg;

  // Transaction field widths
  localparam int OPCODE_W    = 2;
  localparam int ENTITY_W    = 8;
  localparam int COMPONENT_W = 3;
  localparam int SLOT_OUT_W  = 8;
  localparam int STATUS_W    = 2;
  localparam int TDATA_W     = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd3;

  // Commands from the sequencer to the pool
  typedef struct packed {
    logic rd;         // read the free FIFO head for the addressed pool
    logic pop;        // consume the free FIFO head
    logic alloc_new;  // hand out the next never-used slot
    logic push;       // return a slot to the free FIFO
  } pool_cmd_t;

  // Pool availability for the addressed component
  typedef struct packed {
    logic free_avail;  // free FIFO holds at least one slot
    logic new_avail;   // unused slots remain
  } pool_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/component_slot_allocator.sv
// Top level: index table, transaction sequencer and result register.
//
//  Channel | Dir | Handshake          | Payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: opcode, entity, component
//  m_      | out | m_tvalid/m_tready  | m_tdata: slot, present, status
//
// Each transaction has an accept cycle that issues the index table and free FIFO
// reads, then an execute cycle that writes both back and loads the result
// register. Execute holds while the result register is full and m_tready is
// low. After reset a clearing pass writes every table entry before s_tready
// rises. Pool pointers and counts reset at once.
`default_nettype none
module component_slot_allocator #(
  parameter int ENTITIES            = 256,
  parameter int COMPONENTS          = 8,
  parameter int SLOTS_PER_COMPONENT = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // [1:0] opcode, [9:2] entity, [12:10] component, [15:13] zero
  input  wire logic [csa_pkg::TDATA_W-1:0] s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [7:0] slot, [8] present, [10:9] status, [15:11] zero
  output logic      [csa_pkg::TDATA_W-1:0] m_tdata
);
  localparam int COMP_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int SLOT_W = $clog2(SLOTS_PER_COMPONENT);
  localparam int PAIRS  = ENTITIES * COMPONENTS;
  localparam int PAIR_W = $clog2(PAIRS);
  localparam int TBL_W  = SLOT_W + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [csa_pkg::OPCODE_W-1:0]    in_opcode;
  logic [csa_pkg::ENTITY_W-1:0]    in_entity;
  logic [csa_pkg::COMPONENT_W-1:0] in_component;
  logic                            in_range;
  logic [31:0]                     idx_full;
  logic [31:0]                     comp_ext;
  logic                            accept;
  logic                            commit;

  logic [csa_pkg::OPCODE_W-1:0] op_q;
  logic                         in_range_q;
  logic [PAIR_W-1:0]            idx_q;
  logic [COMP_W-1:0]            comp_q;
  logic [PAIR_W-1:0]            clr_addr;

  logic              tbl_we;
  logic [PAIR_W-1:0] tbl_waddr;
  logic [TBL_W-1:0]  tbl_wdata;
  logic [TBL_W-1:0]  tbl_rdata;
  logic              tbl_valid;
  logic [SLOT_W-1:0] tbl_slot;

  csa_pkg::pool_cmd_t  pool_cmd;
  csa_pkg::pool_stat_t pool_stat;
  logic [COMP_W-1:0]   pool_comp;
  logic [SLOT_W-1:0]   free_slot;
  logic [SLOT_W-1:0]   new_slot;

  logic                         x_tbl_we;
  logic [TBL_W-1:0]             x_tbl_wdata;
  logic                         x_pop;
  logic                         x_alloc;
  logic                         x_push;
  logic [SLOT_W-1:0]            res_slot;
  logic                         res_present;
  logic [csa_pkg::STATUS_W-1:0] res_status;
  logic [31:0]                  res_slot_ext;

  logic [csa_pkg::SLOT_OUT_W-1:0] out_slot;
  logic                           out_present;
  logic [csa_pkg::STATUS_W-1:0]   out_status;

  // Input decode
  assign in_opcode    = s_tdata[1:0];
  assign in_entity    = s_tdata[9:2];
  assign in_component = s_tdata[12:10];
  assign in_range     = (32'(in_entity) < ENTITIES) && (32'(in_component) < COMPONENTS);
  assign idx_full     = 32'(in_entity) * 32'(COMPONENTS) + 32'(in_component);
  assign comp_ext     = 32'(in_component);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == S_EXEC) && (!m_tvalid || m_tready);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (32'(clr_addr) == PAIRS - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= in_opcode;
      in_range_q <= in_range;
      idx_q      <= idx_full[PAIR_W-1:0];
      comp_q     <= comp_ext[COMP_W-1:0];
    end
  end

  // Index table: clearing pass or execute write-back
  assign tbl_we    = (state == S_CLEAR) || (commit && x_tbl_we);
  assign tbl_waddr = (state == S_CLEAR) ? clr_addr : idx_q;
  assign tbl_wdata = (state == S_CLEAR) ? '0 : x_tbl_wdata;
  assign tbl_valid = tbl_rdata[SLOT_W];
  assign tbl_slot  = tbl_rdata[SLOT_W-1:0];

  csa_ram #(
    .WIDTH (TBL_W),
    .DEPTH (PAIRS)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (accept && in_range),
    .raddr (idx_full[PAIR_W-1:0]),
    .rdata (tbl_rdata)
  );

  // Pool sees the incoming component at accept, the held one at execute
  assign pool_comp          = (state == S_EXEC) ? comp_q : comp_ext[COMP_W-1:0];
  assign pool_cmd.rd        = accept && in_range;
  assign pool_cmd.pop       = commit && x_pop;
  assign pool_cmd.alloc_new = commit && x_alloc;
  assign pool_cmd.push      = commit && x_push;

  csa_pool #(
    .COMPONENTS          (COMPONENTS),
    .SLOTS_PER_COMPONENT (SLOTS_PER_COMPONENT)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pool_cmd),
    .comp      (pool_comp),
    .push_slot (tbl_slot),
    .stat      (pool_stat),
    .free_slot (free_slot),
    .new_slot  (new_slot)
  );

  // Execute: decide result and write-back from the table entry
  always_comb begin
    x_tbl_we    = 1'b0;
    x_tbl_wdata = '0;
    x_pop       = 1'b0;
    x_alloc     = 1'b0;
    x_push      = 1'b0;
    res_slot    = '0;
    res_present = 1'b0;
    res_status  = csa_pkg::STAT_ABSENT;
    if (!in_range_q) begin
      res_status = (op_q == csa_pkg::OP_ADD) ? csa_pkg::STAT_FULL : csa_pkg::STAT_ABSENT;
    end else begin
      unique case (op_q)
        csa_pkg::OP_ADD: begin
          if (tbl_valid) begin
            res_slot    = tbl_slot;
            res_present = 1'b1;
            res_status  = csa_pkg::STAT_PRESENT;
          end else if (pool_stat.free_avail) begin
            x_pop       = 1'b1;
            x_tbl_we    = 1'b1;
            x_tbl_wdata = {1'b1, free_slot};
            res_slot    = free_slot;
            res_present = 1'b1;
            res_status  = csa_pkg::STAT_OK;
          end else if (pool_stat.new_avail) begin
            x_alloc     = 1'b1;
            x_tbl_we    = 1'b1;
            x_tbl_wdata = {1'b1, new_slot};
            res_slot    = new_slot;
            res_present = 1'b1;
            res_status  = csa_pkg::STAT_OK;
          end else begin
            res_status = csa_pkg::STAT_FULL;
          end
        end
        csa_pkg::OP_RELEASE: begin
          if (tbl_valid) begin
            x_push      = 1'b1;
            x_tbl_we    = 1'b1;
            x_tbl_wdata = '0;
            res_slot    = tbl_slot;
            res_status  = csa_pkg::STAT_OK;
          end
        end
        default: begin
          // look up; the unused opcode behaves the same
          if (tbl_valid) begin
            res_slot    = tbl_slot;
            res_present = 1'b1;
            res_status  = csa_pkg::STAT_OK;
          end
        end
      endcase
    end
  end

  assign res_slot_ext = 32'(res_slot);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_slot    <= res_slot_ext[csa_pkg::SLOT_OUT_W-1:0];
      out_present <= res_present;
      out_status  <= res_status;
    end
  end

  assign m_tdata = {5'b0, out_status, out_present, out_slot};

endmodule
`default_nettype wire

>>> rtl/core/csa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/csa_pool.sv
// Per-component slot pools: free FIFO storage, pointers and high-water counts.
`default_nettype none
module csa_pool #(
  parameter int COMPONENTS          = 8,
  parameter int SLOTS_PER_COMPONENT = 256
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire csa_pkg::pool_cmd_t                              cmd,
  input  wire logic [((COMPONENTS > 1) ? $clog2(COMPONENTS) : 1)-1:0] comp,
  input  wire logic [$clog2(SLOTS_PER_COMPONENT)-1:0]          push_slot,
  output csa_pkg::pool_stat_t                                  stat,
  output logic      [$clog2(SLOTS_PER_COMPONENT)-1:0]          free_slot,
  output logic      [$clog2(SLOTS_PER_COMPONENT)-1:0]          new_slot
);
  localparam int COMP_W     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int SLOT_W     = $clog2(SLOTS_PER_COMPONENT);
  localparam int FIFO_DEPTH = COMPONENTS * SLOTS_PER_COMPONENT;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  logic [SLOT_W-1:0] head  [COMPONENTS];
  logic [SLOT_W-1:0] tail  [COMPONENTS];
  logic [SLOT_W:0]   count [COMPONENTS];
  logic [SLOT_W:0]   used  [COMPONENTS];

  logic [31:0]        rd_full;
  logic [31:0]        wr_full;
  logic [SLOT_W-1:0]  head_inc;
  logic [SLOT_W-1:0]  tail_inc;
  logic               room;
  logic               fifo_we;

  // Pointer wrap modulo the pool size
  assign head_inc = (32'(head[comp]) == SLOTS_PER_COMPONENT - 1) ? '0 : head[comp] + 1'b1;
  assign tail_inc = (32'(tail[comp]) == SLOTS_PER_COMPONENT - 1) ? '0 : tail[comp] + 1'b1;

  // FIFO storage addresses: pool base plus pointer
  assign rd_full = 32'(comp) * 32'(SLOTS_PER_COMPONENT) + 32'(head[comp]);
  assign wr_full = 32'(comp) * 32'(SLOTS_PER_COMPONENT) + 32'(tail[comp]);

  assign room    = 32'(count[comp]) < SLOTS_PER_COMPONENT;
  assign fifo_we = cmd.push && room;

  assign stat.free_avail = (count[comp] != '0);
  assign stat.new_avail  = 32'(used[comp]) < SLOTS_PER_COMPONENT;
  assign new_slot        = used[comp][SLOT_W-1:0];

  csa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wr_full[FIFO_AW-1:0]),
    .wdata (push_slot),
    .re    (cmd.rd),
    .raddr (rd_full[FIFO_AW-1:0]),
    .rdata (free_slot)
  );

  // Pointer and count updates; at most one of pop, alloc and push per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMPONENTS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
        used[i]  <= '0;
      end
    end else begin
      if (cmd.pop) begin
        head[comp]  <= head_inc;
        count[comp] <= count[comp] - 1'b1;
      end else if (fifo_we) begin
        tail[comp]  <= tail_inc;
        count[comp] <= count[comp] + 1'b1;
      end
      if (cmd.alloc_new) begin
        used[comp] <= used[comp] + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the component slot allocator: stream driver, monitor, predictor.
module tb;

  localparam int N_ENT  = 256;
  localparam int N_COMP = 8;
  localparam int N_SLOT = 256;
  // Spare opcode behaves as a look up
  localparam logic [csa_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [csa_pkg::OPCODE_W-1:0]    op;
    logic [csa_pkg::ENTITY_W-1:0]    ent;
    logic [csa_pkg::COMPONENT_W-1:0] comp;
    bit                              drain;  // hold off until all replies are back
  } slot_request_t;

  typedef struct {
    logic [csa_pkg::SLOT_OUT_W-1:0] slot;
    logic                           present;
    logic [csa_pkg::STATUS_W-1:0]   status;
  } slot_reply_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [csa_pkg::TDATA_W-1:0]  s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [csa_pkg::TDATA_W-1:0]  m_tdata;

  component_slot_allocator #(
    .ENTITIES(N_ENT),
    .COMPONENTS(N_COMP),
    .SLOTS_PER_COMPONENT(N_SLOT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  slot_request_t pending_requests[$];
  slot_reply_t   replies_due[$];
  int            mismatches = 0;
  int            cycle_cnt = 0;
  int            status_seen[4] = '{0, 0, 0, 0};
  int            requests_sent = 0;

  // Predictor state: pair table and per-type pools
  bit                             pair_held[N_ENT][N_COMP];
  logic [csa_pkg::SLOT_OUT_W-1:0] pair_slot[N_ENT][N_COMP];
  logic [csa_pkg::SLOT_OUT_W-1:0] freed_slots[N_COMP][N_SLOT];
  int                             freed_rd[N_COMP];
  int                             freed_wr[N_COMP];
  int                             freed_cnt[N_COMP];
  int                             fresh_next[N_COMP];

  // Stimulus generator bookkeeping: which pairs hold a slot
  bit gen_held[N_ENT][N_COMP];
  int gen_held_list[$];

  // Quiet windows where neither side idles
  wire calm = (cycle_cnt % 3000) >= 2200;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Compute the reply for one request and update the pool state
  function automatic slot_reply_t serve_request(logic [csa_pkg::OPCODE_W-1:0] op,
                                                logic [csa_pkg::ENTITY_W-1:0] ent,
                                                logic [csa_pkg::COMPONENT_W-1:0] comp);
    slot_reply_t r;
    int          s;
    r.slot    = '0;
    r.present = 1'b0;
    r.status  = csa_pkg::STAT_OK;
    if (ent >= N_ENT || comp >= N_COMP) begin
      r.status = (op == csa_pkg::OP_ADD) ? csa_pkg::STAT_FULL : csa_pkg::STAT_ABSENT;
      return r;
    end
    if (op == csa_pkg::OP_ADD) begin
      if (pair_held[ent][comp]) begin
        r.slot    = pair_slot[ent][comp];
        r.present = 1'b1;
        r.status  = csa_pkg::STAT_PRESENT;
        return r;
      end
      if (freed_cnt[comp] > 0) begin
        s = freed_slots[comp][freed_rd[comp]];
        freed_rd[comp] = (freed_rd[comp] + 1) % N_SLOT;
        freed_cnt[comp]--;
      end else if (fresh_next[comp] < N_SLOT) begin
        s = fresh_next[comp];
        fresh_next[comp]++;
      end else begin
        r.status = csa_pkg::STAT_FULL;
        return r;
      end
      pair_held[ent][comp] = 1'b1;
      pair_slot[ent][comp] = s[csa_pkg::SLOT_OUT_W-1:0];
      r.slot    = s[csa_pkg::SLOT_OUT_W-1:0];
      r.present = 1'b1;
      return r;
    end
    if (op == csa_pkg::OP_RELEASE) begin
      if (!pair_held[ent][comp]) begin
        r.status = csa_pkg::STAT_ABSENT;
        return r;
      end
      r.slot = pair_slot[ent][comp];
      if (freed_cnt[comp] < N_SLOT) begin
        freed_slots[comp][freed_wr[comp]] = pair_slot[ent][comp];
        freed_wr[comp] = (freed_wr[comp] + 1) % N_SLOT;
        freed_cnt[comp]++;
      end
      pair_held[ent][comp] = 1'b0;
      pair_slot[ent][comp] = '0;
      return r;
    end
    // look up, spare opcode included
    if (pair_held[ent][comp]) begin
      r.slot    = pair_slot[ent][comp];
      r.present = 1'b1;
    end else begin
      r.status = csa_pkg::STAT_ABSENT;
    end
    return r;
  endfunction

  // Queue one request, tracking which pairs the stimulus expects to be held
  task automatic queue_request(logic [csa_pkg::OPCODE_W-1:0] op, int ent, int comp,
                               bit drain = 0);
    slot_request_t q;
    int            key;
    q.op    = op;
    q.ent   = ent[csa_pkg::ENTITY_W-1:0];
    q.comp  = comp[csa_pkg::COMPONENT_W-1:0];
    q.drain = drain;
    key     = ent * N_COMP + comp;
    if (op == csa_pkg::OP_ADD && !gen_held[ent][comp]) begin
      gen_held[ent][comp] = 1'b1;
      gen_held_list.insert(gen_held_list.size(), key);
    end else if (op == csa_pkg::OP_RELEASE && gen_held[ent][comp]) begin
      gen_held[ent][comp] = 1'b0;
      foreach (gen_held_list[i]) begin
        if (gen_held_list[i] == key) begin
          gen_held_list.delete(i);
          break;
        end
      end
    end
    pending_requests.insert(pending_requests.size(), q);
  endtask

  // Pick a component, biased toward two hot pools so their FIFOs wrap
  function automatic int pick_comp();
    if ($urandom_range(99) < 50) return ($urandom_range(1) != 0) ? 7 : 0;
    return $urandom_range(N_COMP - 1);
  endfunction

  // Source driver: presents queued requests, predicts on each accepted transaction
  always @(posedge clk) begin : source_drive
    bit            fire;
    bit            load;
    slot_request_t nxt;
    slot_reply_t   pred;
    fire = s_tvalid && s_tready;
    if (fire) begin
      pred = serve_request(s_tdata[1:0], s_tdata[9:2], s_tdata[12:10]);
      replies_due.insert(replies_due.size(), pred);
      requests_sent++;
    end
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (fire || !s_tvalid) begin
      load = pending_requests.size() > 0;
      if (load && !calm && $urandom_range(99) < 20) load = 0;
      if (load && pending_requests[0].drain && replies_due.size() != 0) load = 0;
      if (load) begin
        nxt = pending_requests.pop_front();
        s_tdata <= {3'b000, nxt.comp, nxt.ent, nxt.op};
      end
      s_tvalid <= load;
    end
  end

  // Result monitor: random backpressure, compares each reply with the oldest prediction
  always @(posedge clk) begin : reply_watch
    slot_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected reply transaction: m_tdata=%h", m_tdata);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          status_seen[want.status]++;
          if (m_tdata[7:0] !== want.slot) begin
            $error("slot mismatch: expected %0d, got %0d", want.slot, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tdata[8] !== want.present) begin
            $error("present mismatch: expected %0d, got %0d", want.present, m_tdata[8]);
            mismatches++;
          end
          if (m_tdata[10:9] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, m_tdata[10:9]);
            mismatches++;
          end
        end
      end
      m_tready <= calm || $urandom_range(99) >= 20;
    end
  end

  // Stimulus and end of test
  initial begin : stimulus
    int order[$];
    int idx;
    int tmp;
    int r;
    int ent;
    int comp;
    int key;
    for (int e = 0; e < N_ENT; e++) begin
      for (int c = 0; c < N_COMP; c++) begin
        pair_held[e][c] = 1'b0;
        pair_slot[e][c] = '0;
        gen_held[e][c]  = 1'b0;
      end
    end
    for (int c = 0; c < N_COMP; c++) begin
      freed_rd[c]   = 0;
      freed_wr[c]   = 0;
      freed_cnt[c]  = 0;
      fresh_next[c] = 0;
    end

    // Directed: duplicate add, spare opcode, absent look up/release, slot reuse, extremes
    queue_request(csa_pkg::OP_ADD,     0,   0);
    queue_request(csa_pkg::OP_ADD,     0,   0);
    queue_request(csa_pkg::OP_LOOKUP,  0,   0);
    queue_request(OP_SPARE,            0,   0);
    queue_request(csa_pkg::OP_ADD,     255, 7);
    queue_request(csa_pkg::OP_ADD,     255, 0);
    queue_request(csa_pkg::OP_RELEASE, 0,   0);
    queue_request(csa_pkg::OP_RELEASE, 0,   0);
    queue_request(csa_pkg::OP_LOOKUP,  0,   0);
    queue_request(OP_SPARE,            0,   0);
    queue_request(csa_pkg::OP_ADD,     128, 0);
    queue_request(csa_pkg::OP_LOOKUP,  128, 0);
    queue_request(csa_pkg::OP_RELEASE, 170, 5);
    queue_request(csa_pkg::OP_ADD,     85,  2);
    queue_request(csa_pkg::OP_LOOKUP,  255, 7);
    queue_request(csa_pkg::OP_RELEASE, 255, 7, 1);
    queue_request(csa_pkg::OP_ADD,     1,   7);
    queue_request(OP_SPARE,            255, 0);
    queue_request(csa_pkg::OP_RELEASE, 85,  2);

    // Fill every slot of pool 7 in random entity order, with some look ups mixed in
    for (int e = 0; e < N_ENT; e++) if (!gen_held[e][7]) order.insert(order.size(), e);
    for (int i = order.size() - 1; i > 0; i--) begin
      idx = $urandom_range(i);
      tmp = order[i];
      order[i] = order[idx];
      order[idx] = tmp;
    end
    foreach (order[i]) begin
      queue_request(csa_pkg::OP_ADD, order[i], 7);
      if ($urandom_range(99) < 10) begin
        queue_request(csa_pkg::OP_LOOKUP, $urandom_range(N_ENT - 1), 7);
      end
    end

    // Random mix: mostly operations on held pairs, some noise on arbitrary pairs
    for (int n = 0; n < 1650; n++) begin
      r    = $urandom_range(99);
      ent  = $urandom_range(N_ENT - 1);
      comp = pick_comp();
      if (gen_held_list.size() > 0 &&
          (r < 40 ? $urandom_range(99) < 15 : $urandom_range(99) < 75)) begin
        key  = gen_held_list[$urandom_range(gen_held_list.size() - 1)];
        ent  = key / N_COMP;
        comp = key % N_COMP;
      end
      if (r < 40)      queue_request(csa_pkg::OP_ADD,     ent, comp, n == 800);
      else if (r < 65) queue_request(csa_pkg::OP_LOOKUP,  ent, comp, n == 800);
      else if (r < 93) queue_request(csa_pkg::OP_RELEASE, ent, comp, n == 800);
      else             queue_request(OP_SPARE,            ent, comp, n == 800);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_tvalid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests through pool fill, slot reuse and FIFO wrap; replies:",
             requests_sent);
    $display("  ok %0d, already present %0d, pool full %0d, not present %0d",
             status_seen[csa_pkg::STAT_OK], status_seen[csa_pkg::STAT_PRESENT],
             status_seen[csa_pkg::STAT_FULL], status_seen[csa_pkg::STAT_ABSENT]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d replies still outstanding", replies_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
